>>> hdl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/mlbc_pkg.sv
`timescale 1ns / 1ps

package mlbc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned INTV_W   = 8;
  localparam int unsigned ID_W     = 2;
  localparam int unsigned REG_W    = 4;
  localparam int unsigned UNIT_W   = 7;
  localparam int unsigned DUE_W    = INTV_W + UNIT_W;

  localparam logic [UNIT_W-1:0] INTERVAL_UNIT_MS = 7'd100;

  localparam logic [REG_W-1:0] REG_LIGHTS_RST = 4'hF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUT  = 1'b1;

  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STEADY = 2'd1,
    MODE_FLASH  = 2'd2
  } light_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_STEADY = 4'b0010,
    ST_FLASH  = 4'b0100,
    ST_FLUSH  = 4'b1000
  } seq_state_t;

endpackage

>>> hdl/mlbc_due_unit.sv
`timescale 1ns / 1ps

module mlbc_due_unit (
  input  logic [mlbc_pkg::TIME_W-1:0] now_ms,
  input  logic [mlbc_pkg::TIME_W-1:0] toggle_ms,
  input  logic [mlbc_pkg::INTV_W-1:0] interval,
  output logic                        due
);
  import mlbc_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic [DUE_W-1:0]  due_ms;

  assign elapsed = now_ms - toggle_ms;
  assign due_ms  = DUE_W'(interval) * DUE_W'(INTERVAL_UNIT_MS);

  // Signed elapsed <= 0 always toggles.
  assign due = (elapsed == '0) || elapsed[TIME_W-1] ||
               (elapsed >= TIME_W'(due_ms));

endmodule

>>> hdl/multi_light_blink_controller_unit.sv
`timescale 1ns / 1ps
// Multi-light blink controller.
// Input: pulse start with the in_* fields while busy is low. in_op selects a
// put (set one light's level and interval) or a tick (in_now_ms = time in ms).
// Results: one per cycle on out_* with out_valid high for exactly one cycle;
// the receiver cannot stall, so every strobe is a completed transaction.
// out_last marks the final result of an input transaction.
// Put: status appears the cycle after acceptance; busy stays low, so puts can
// follow back to back.
// Tick: busy while the sequencer walks every light once for steady drives
// and once more for flash checks through the single shared elapsed-time
// comparator, then flushes the held result. A drive is held until the next
// hit or the flush, then registered; the final one shows in the first cycle
// with busy low. A tick that drives nothing gives no result.
// Configuration: cfg_wr_en/cfg_wr_data write the registered-light mask at any
// clock edge; only write it while busy is low.
// Reset (synchronous, rst_n low): all lights idle, mask all ones, no output.
module multi_light_blink_controller_unit #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [mlbc_pkg::ID_W-1:0]     in_light_id,
  input  logic [mlbc_pkg::LEVEL_W-1:0]  in_level_in,
  input  logic [mlbc_pkg::INTV_W-1:0]   in_interval_in,
  input  logic [mlbc_pkg::TIME_W-1:0]   in_now_ms,
  input  logic                          cfg_wr_en,
  input  logic [mlbc_pkg::REG_W-1:0]    cfg_wr_data,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [mlbc_pkg::ID_W-1:0]     out_light_out,
  output logic [mlbc_pkg::LEVEL_W-1:0]  out_drive_level,
  output logic                          out_failed,
  output logic                          out_last
);
  import mlbc_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W  = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int CNT_W  = $clog2(NUM_LIGHTS + 1);
  localparam int SCAN_W = (CNT_W < 2) ? 2 : CNT_W;
  localparam logic [SCAN_W-1:0] LAST_IDX = SCAN_W'(NUM_LIGHTS - 1);

  seq_state_t           state_r, state_nxt;
  logic [SCAN_W-1:0]    idx_r, idx_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [REG_W-1:0]     reg_lights_r, reg_lights_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]      pend_light_r, pend_light_nxt;
  logic [LEVEL_W-1:0]   pend_level_r, pend_level_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]      out_light_r, out_light_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                 out_failed_r, out_failed_nxt;
  logic                 out_last_r, out_last_nxt;

  light_mode_t          mode_r  [NUM_LIGHTS];
  logic [LEVEL_W-1:0]   level_r [NUM_LIGHTS];
  logic [INTV_W-1:0]    intv_r  [NUM_LIGHTS];
  logic [TIME_W-1:0]    ltt_r   [NUM_LIGHTS];
  logic [LEVEL_W-1:0]   lout_r  [NUM_LIGHTS];

  logic [IDX_W-1:0]     cur;
  logic [IDX_W+ID_W-1:0] put_id_ext;
  logic [IDX_W-1:0]     put_idx;
  logic                 put_ok;
  logic                 put_we;
  logic                 steady_clr;
  logic                 flash_we;
  logic                 hit;
  logic [LEVEL_W-1:0]   hit_level;
  logic                 flash_due;
  logic                 last_idx;

  assign cur        = idx_r[IDX_W-1:0];
  assign put_id_ext = {{IDX_W{1'b0}}, in_light_id};
  assign put_idx    = put_id_ext[IDX_W-1:0];
  assign put_ok     = ({30'd0, in_light_id} < 32'(NUM_LIGHTS)) &&
                      reg_lights_r[in_light_id];
  assign last_idx   = (idx_r == LAST_IDX);
  assign busy       = (state_r != ST_IDLE);

  mlbc_due_unit u_due (
    .now_ms    (now_r),
    .toggle_ms (ltt_r[cur]),
    .interval  (intv_r[cur]),
    .due       (flash_due)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    reg_lights_nxt = cfg_wr_en ? cfg_wr_data : reg_lights_r;
    pend_v_nxt     = pend_v_r;
    pend_light_nxt = pend_light_r;
    pend_level_nxt = pend_level_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_light_nxt  = out_light_r;
    out_level_nxt  = out_level_r;
    out_failed_nxt = out_failed_r;
    out_last_nxt   = out_last_r;
    put_we         = 1'b0;
    steady_clr     = 1'b0;
    flash_we       = 1'b0;
    hit            = 1'b0;
    hit_level      = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_PUT) begin
            put_we         = put_ok;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_STATUS;
            out_light_nxt  = in_light_id;
            out_level_nxt  = '0;
            out_failed_nxt = !put_ok;
            out_last_nxt   = 1'b1;
          end else begin
            now_nxt   = in_now_ms;
            idx_nxt   = '0;
            state_nxt = ST_STEADY;
          end
        end
      end
      ST_STEADY: begin
        hit        = (mode_r[cur] == MODE_STEADY);
        hit_level  = level_r[cur];
        steady_clr = hit;
        idx_nxt    = idx_r + 1'b1;
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = ST_FLASH;
        end
      end
      ST_FLASH: begin
        hit       = (mode_r[cur] == MODE_FLASH) && flash_due;
        hit_level = (lout_r[cur] == '0) ? level_r[cur] : '0;
        flash_we  = hit;
        idx_nxt   = idx_r + 1'b1;
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DRIVE;
          out_light_nxt  = pend_light_r;
          out_level_nxt  = pend_level_r;
          out_failed_nxt = 1'b0;
          out_last_nxt   = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
    endcase

    // Hold one drive back so the final one can carry out_last.
    if (hit) begin
      if (pend_v_r) begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_DRIVE;
        out_light_nxt  = pend_light_r;
        out_level_nxt  = pend_level_r;
        out_failed_nxt = 1'b0;
        out_last_nxt   = 1'b0;
      end
      pend_v_nxt     = 1'b1;
      pend_light_nxt = idx_r[ID_W-1:0];
      pend_level_nxt = hit_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      reg_lights_r <= REG_LIGHTS_RST;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      reg_lights_r <= reg_lights_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    pend_light_r <= pend_light_nxt;
    pend_level_r <= pend_level_nxt;
    out_kind_r   <= out_kind_nxt;
    out_light_r  <= out_light_nxt;
    out_level_r  <= out_level_nxt;
    out_failed_r <= out_failed_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        mode_r[i] <= MODE_IDLE;
      end
    end else if (put_we) begin
      mode_r[put_idx] <= (in_interval_in == '0) ? MODE_STEADY : MODE_FLASH;
    end else if (steady_clr) begin
      mode_r[cur] <= MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (put_we) begin
      level_r[put_idx] <= in_level_in;
      intv_r[put_idx]  <= in_interval_in;
      if (in_interval_in != '0) begin
        ltt_r[put_idx]  <= in_now_ms;
        lout_r[put_idx] <= '0;
      end
    end else if (flash_we) begin
      ltt_r[cur]  <= now_r;
      lout_r[cur] <= hit_level;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_light_out   = out_light_r;
  assign out_drive_level = out_level_r;
  assign out_failed      = out_failed_r;
  assign out_last        = out_last_r;

  `ASSERT_CLK(a_put_status, (start && !busy && (in_op == OP_PUT)) |=> (out_valid && out_last && (out_kind == KIND_STATUS)), "put without status")
  `ASSERT_CLK(a_tick_quiet, (start && !busy && (in_op == OP_TICK)) |=> !out_valid, "output right after tick")
  `ASSERT_NEVER(a_pend_idle, (state_r == ST_IDLE) && pend_v_r, "held drive left in idle")
  `ASSERT_CLK(a_drive_busy, (out_valid && (out_kind == KIND_DRIVE)) |-> $past(busy), "drive outside a tick")

endmodule

>>> tb/blink_result_monitor.sv
`timescale 1ns / 1ps

module blink_result_monitor
  import mlbc_pkg::*;
#(
  parameter int NUM_LIGHTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_op,
  input  logic [ID_W-1:0]    in_light_id,
  input  logic [LEVEL_W-1:0] in_level_in,
  input  logic [INTV_W-1:0]  in_interval_in,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               cfg_wr_en,
  input  logic [REG_W-1:0]   cfg_wr_data,
  input  logic               out_valid,
  input  logic               out_kind,
  input  logic [ID_W-1:0]    out_light_out,
  input  logic [LEVEL_W-1:0] out_drive_level,
  input  logic               out_failed,
  input  logic               out_last,
  output int                 err_count,
  output int                 due_count
);

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    light;
    logic [LEVEL_W-1:0] level;
    logic               failed;
    logic               last;
  } light_event_t;

  light_event_t       events_due[$];
  logic [REG_W-1:0]   lights_enabled;
  light_mode_t        mode_q[NUM_LIGHTS];
  logic [LEVEL_W-1:0] level_q[NUM_LIGHTS];
  logic [INTV_W-1:0]  intv_q[NUM_LIGHTS];
  logic [TIME_W-1:0]  toggled_at[NUM_LIGHTS];
  logic [LEVEL_W-1:0] shown[NUM_LIGHTS];

  task automatic advance_lights(input logic op, input logic [ID_W-1:0] id,
                                input logic [LEVEL_W-1:0] level,
                                input logic [INTV_W-1:0] intv,
                                input logic [TIME_W-1:0] now);
    light_event_t      batch[$];
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] due;
    logic              ok;
    if (op == OP_PUT) begin
      ok = (int'(id) < NUM_LIGHTS) && lights_enabled[id];
      if (ok) begin
        level_q[id] = level;
        intv_q[id] = intv;
        if (intv == '0) begin
          mode_q[id] = MODE_STEADY;
        end else begin
          mode_q[id] = MODE_FLASH;
          toggled_at[id] = now;
          shown[id] = '0;
        end
      end
      events_due.push_back('{KIND_STATUS, id, LEVEL_W'(0), !ok, 1'b1});
    end else begin
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        if (mode_q[i] == MODE_STEADY) begin
          batch.push_back('{KIND_DRIVE, ID_W'(i), level_q[i], 1'b0, 1'b0});
          mode_q[i] = MODE_IDLE;
        end
      end
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        if (mode_q[i] == MODE_FLASH) begin
          elapsed = now - toggled_at[i];
          due = TIME_W'(intv_q[i]) * TIME_W'(INTERVAL_UNIT_MS);
          // zero or negative elapsed time (clock went back) forces a toggle
          if (elapsed == '0 || elapsed[TIME_W-1] || elapsed >= due) begin
            shown[i] = (shown[i] == '0) ? level_q[i] : '0;
            toggled_at[i] = now;
            batch.push_back('{KIND_DRIVE, ID_W'(i), shown[i], 1'b0, 1'b0});
          end
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) events_due.push_back(batch[k]);
    end
  endtask

  task automatic check_result();
    light_event_t exp_ev;
    if (events_due.size() == 0) begin
      $error("unexpected transaction: kind %0d light %0d level %0d",
             out_kind, out_light_out, out_drive_level);
      err_count++;
    end else begin
      exp_ev = events_due.pop_front();
      if (out_kind !== exp_ev.kind) begin
        $error("kind: expected %0d, got %0d", exp_ev.kind, out_kind);
        err_count++;
      end
      if (out_light_out !== exp_ev.light) begin
        $error("light_out: expected %0d, got %0d", exp_ev.light, out_light_out);
        err_count++;
      end
      if (out_drive_level !== exp_ev.level) begin
        $error("drive_level: expected %0d, got %0d", exp_ev.level, out_drive_level);
        err_count++;
      end
      if (out_failed !== exp_ev.failed) begin
        $error("failed: expected %0d, got %0d", exp_ev.failed, out_failed);
        err_count++;
      end
      if (out_last !== exp_ev.last) begin
        $error("last: expected %0d, got %0d", exp_ev.last, out_last);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lights_enabled = REG_LIGHTS_RST;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        mode_q[i] = MODE_IDLE;
        level_q[i] = '0;
        intv_q[i] = '0;
        toggled_at[i] = '0;
        shown[i] = '0;
      end
      events_due.delete();
      err_count = 0;
    end else begin
      if (cfg_wr_en) lights_enabled = cfg_wr_data;
      if (start && !busy) begin
        advance_lights(in_op, in_light_id, in_level_in, in_interval_in, in_now_ms);
      end
      if (out_valid) check_result();
    end
    due_count = events_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mlbc_pkg::*;

  localparam int NUM_LIGHTS    = 4;
  localparam int SETTLE_CYCLES = 2 * NUM_LIGHTS + 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 53;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [ID_W-1:0]    in_light_id;
  logic [LEVEL_W-1:0] in_level_in;
  logic [INTV_W-1:0]  in_interval_in;
  logic [TIME_W-1:0]  in_now_ms;
  logic               cfg_wr_en;
  logic [REG_W-1:0]   cfg_wr_data;
  logic               out_valid;
  logic               out_kind;
  logic [ID_W-1:0]    out_light_out;
  logic [LEVEL_W-1:0] out_drive_level;
  logic               out_failed;
  logic               out_last;
  int                 err_count;
  int                 due_count;

  logic [TIME_W-1:0]  clock_ms;
  logic               no_gaps;

  multi_light_blink_controller_unit #(.NUM_LIGHTS(NUM_LIGHTS)) DUT (.*);

  blink_result_monitor #(.NUM_LIGHTS(NUM_LIGHTS)) u_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 8);
    else return $urandom_range(10, 40);
  endfunction

  task automatic issue(input logic op, input logic [ID_W-1:0] id,
                       input logic [LEVEL_W-1:0] level,
                       input logic [INTV_W-1:0] intv,
                       input logic [TIME_W-1:0] now);
    int gap;
    start <= 1'b1;
    in_op <= op;
    in_light_id <= id;
    in_level_in <= level;
    in_interval_in <= intv;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_light(input logic [ID_W-1:0] id, input logic [LEVEL_W-1:0] level,
                           input logic [INTV_W-1:0] intv, input logic [TIME_W-1:0] now);
    issue(OP_PUT, id, level, intv, now);
  endtask

  task automatic tick(input logic [TIME_W-1:0] now);
    issue(OP_TICK, ID_W'($urandom), LEVEL_W'($urandom), INTV_W'($urandom), now);
  endtask

  // Ticks that drive nothing give no transaction, so wait out the walk too.
  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    for (int n = 0; n < 2000 && (due_count != 0 || busy); n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [REG_W-1:0] mask);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int                 r;
    logic               op;
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
    logic [INTV_W-1:0]  intv;
    logic [TIME_W-1:0]  now;
    logic [REG_W-1:0]   mask;

    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_TICK;
    in_light_id = '0;
    in_level_in = '0;
    in_interval_in = '0;
    in_now_ms = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    no_gaps = 1'b0;
    clock_ms = 32'd1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_light(2'd0, 8'hFF, 8'd0, 32'd1000);
    put_light(2'd1, 8'h80, 8'd1, 32'd1000);
    put_light(2'd2, 8'h01, 8'd255, 32'd1000);
    put_light(2'd3, 8'h00, 8'd0, 32'd1000);
    tick(32'd1000);
    tick(32'd1099);
    tick(32'd1100);
    tick(32'd900);
    tick(32'd26400);
    put_light(2'd1, 8'h7F, 8'd0, 32'd0);
    tick(32'hFFFF_FFFF);
    put_light(2'd2, 8'hAA, 8'h55, 32'hFFFF_FF00);
    tick(32'h0000_1000);
    tick(32'h0000_2100);
    settle();
    write_mask(4'h5);
    put_light(2'd1, 8'h11, 8'd3, 32'h0000_3000);
    put_light(2'd3, 8'h22, 8'd0, 32'h0000_3000);
    put_light(2'd0, 8'h33, 8'd2, 32'h0000_3000);
    put_light(2'd2, 8'h44, 8'd0, 32'h0000_3000);
    tick(32'h0000_3000);
    settle();
    write_mask(4'h0);
    put_light(2'd0, 8'h55, 8'd0, 32'h0000_3100);
    tick(32'h0000_30C8);
    tick(32'h8000_30C8);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: mask = 4'hF;
        1: mask = 4'h0;
        2: mask = 4'hA;
        3: mask = 4'h5;
        4: mask = 4'hF;
        default: mask = REG_W'($urandom);
      endcase
      write_mask(mask);
      no_gaps = ($urandom_range(3) == 0);
      if (p == 4) clock_ms = 32'hFFFF_F000;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        id = ID_W'($urandom);
        level = LEVEL_W'($urandom);
        if (r < 8) begin
          op = 1'($urandom);
          intv = INTV_W'($urandom);
          now = $urandom;
        end else if (r < 45) begin
          op = OP_PUT;
          r = $urandom_range(99);
          if (r < 25) intv = '0;
          else if (r < 80) intv = INTV_W'($urandom_range(1, 5));
          else if (r < 90) intv = 8'd255;
          else intv = INTV_W'($urandom);
          now = clock_ms;
        end else begin
          op = OP_TICK;
          intv = INTV_W'($urandom);
          r = $urandom_range(99);
          if (r < 50) clock_ms += $urandom_range(1, 250);
          else if (r < 70) clock_ms = clock_ms;
          else if (r < 85) clock_ms += $urandom_range(250, 1000);
          else if (r < 95) clock_ms -= $urandom_range(1, 500);
          else clock_ms += $urandom_range(20000, 30000);
          now = clock_ms;
        end
        issue(op, id, level, intv, now);
      end
      settle();
    end

    if (due_count != 0) $error("%0d expected transactions never arrived", due_count);
    if (err_count == 0 && due_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
